FILE: hw/rtl/ctt_pkg.sv
package ctt_pkg;

    localparam int PosW    = 32;
    localparam int LineW   = 32;
    localparam int OutW    = 32;
    localparam int MaxTok  = 3;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);

    typedef enum logic [4:0] {
        K_EQUAL   = 5'd0,
        K_END     = 5'd1,
        K_KEY     = 5'd2,
        K_LBRACE  = 5'd3,
        K_LPAREN  = 5'd4,
        K_NUMBER  = 5'd5,
        K_HEX     = 5'd6,
        K_RBRACE  = 5'd7,
        K_RPAREN  = 5'd8,
        K_STRING  = 5'd9,
        K_SEMI    = 5'd10,
        K_COMMA   = 5'd11,
        K_FALSE   = 5'd12,
        K_TRUE    = 5'd13,
        K_COLOUR  = 5'd14,
        K_V2      = 5'd15,
        K_V3      = 5'd16,
        K_V4      = 5'd17,
        K_BAD     = 5'd18,
        K_UNTERM  = 5'd19
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_KEY, M_INT, M_DOT, M_FRAC, M_HEX, M_STRING
    } t_mode;

    typedef struct packed {
        t_kind              kind;
        logic [PosW-1:0]    start;
        logic [PosW-1:0]    len;
        logic [LineW-1:0]   line;
    } t_token;

    // Tokens raised by one text byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]         cnt;
        t_token [MaxTok-1:0] tok;
    } t_bundle;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [QPtrW:0]     level;
    } t_qstat;

    localparam logic [PosW-1:0]  PosMax  = '1;
    localparam logic [LineW-1:0] LineMax = '1;

    localparam logic [47:0] KwTrue   = 48'h0000_7472_7565;
    localparam logic [47:0] KwFalse  = 48'h0066_616c_7365;
    localparam logic [47:0] KwColour = 48'h636f_6c6f_7572;
    localparam logic [47:0] KwV2     = 48'h0000_0000_7632;
    localparam logic [47:0] KwV3     = 48'h0000_0000_7633;
    localparam logic [47:0] KwV4     = 48'h0000_0000_7634;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] v);
        return (v == PosMax) ? v : v + 1'b1;
    endfunction

    function automatic logic [PosW-1:0] span(input logic [PosW-1:0] p,
                                             input logic [PosW-1:0] b);
        return (p >= b) ? p - b : '0;
    endfunction

endpackage

FILE: hw/rtl/ctt_if.sv
interface ctt_byte_if;
    import ctt_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ctt_token_if;
    import ctt_pkg::*;
    logic              valid;
    logic              ready;
    logic [4:0]        token_kind;
    logic [OutW-1:0]   start_offset;
    logic [OutW-1:0]   token_length;
    logic [LineW-1:0]  line_number;
    logic              last_of_run;
    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input last_of_run,
                    output ready);
endinterface

FILE: hw/rtl/ctt_front.sv
module ctt_front
    import ctt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_q_full,
    output logic        o_ready,
    output logic        o_push,
    output t_bundle     o_bundle
);

    t_mode             r_mode,   n_mode;
    logic [PosW-1:0]   r_pos,    n_pos;
    logic [PosW-1:0]   r_begin,  n_begin;
    logic [LineW-1:0]  r_line,   n_line;
    logic [47:0]       r_prefix, n_prefix;

    logic              w_take;
    logic              c0_v, c1_v, id_v, again;
    t_token            c0, c1, id;
    logic [PosW-1:0]   w_span, w_dp;
    t_kind             w_kkind;

    assign o_ready = !i_q_full;
    assign w_take  = i_valid && o_ready;
    assign w_span  = span(r_pos, r_begin);
    assign w_dp    = (r_pos > r_begin) ? r_pos - 1'b1 : r_pos;

    // Match closed key against keyword list
    always_comb begin
        w_kkind = K_KEY;
        if      (w_span == PosW'(4) && r_prefix == KwTrue)   w_kkind = K_TRUE;
        else if (w_span == PosW'(5) && r_prefix == KwFalse)  w_kkind = K_FALSE;
        else if (w_span == PosW'(6) && r_prefix == KwColour) w_kkind = K_COLOUR;
        else if (w_span == PosW'(2) && r_prefix == KwV2)     w_kkind = K_V2;
        else if (w_span == PosW'(2) && r_prefix == KwV3)     w_kkind = K_V3;
        else if (w_span == PosW'(2) && r_prefix == KwV4)     w_kkind = K_V4;
    end

    // Close the open token, then scan from idle where needed
    always_comb begin
        n_mode   = r_mode;
        n_begin  = r_begin;
        n_line   = r_line;
        n_prefix = r_prefix;
        again    = 1'b1;
        c0_v     = 1'b0;
        c1_v     = 1'b0;
        id_v     = 1'b0;
        c0       = '{kind: K_NUMBER, start: r_begin, len: w_span, line: r_line};
        c1       = '{kind: K_BAD, start: w_dp, len: PosW'(1), line: r_line};
        id       = '{kind: K_BAD, start: r_pos, len: PosW'(1), line: r_line};

        case (r_mode)
            M_COMMENT: again = (i_byte == "\n") || (i_byte == 8'd0);
            M_KEY: begin
                if (is_letter(i_byte) || is_dig(i_byte)) begin
                    if (w_span < PosW'(6)) n_prefix = {r_prefix[39:0], i_byte};
                    again = 1'b0;
                end else begin
                    c0_v    = 1'b1;
                    c0.kind = w_kkind;
                end
            end
            M_INT: begin
                if (is_dig(i_byte)) again = 1'b0;
                else if (i_byte == ".") begin
                    n_mode = M_DOT;
                    again  = 1'b0;
                end else c0_v = 1'b1;
            end
            M_DOT: begin
                if (is_dig(i_byte)) begin
                    n_mode = M_FRAC;
                    again  = 1'b0;
                end else begin
                    c0_v   = 1'b1;
                    c0.len = span(w_dp, r_begin);
                    c1_v   = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_dig(i_byte)) again = 1'b0;
                else c0_v = 1'b1;
            end
            M_HEX: begin
                if (is_hexd(i_byte)) again = 1'b0;
                else begin
                    c0_v    = 1'b1;
                    c0.kind = K_HEX;
                end
            end
            M_STRING: begin
                if (i_byte == "\"") begin
                    c0_v    = 1'b1;
                    c0.kind = K_STRING;
                    n_mode  = M_IDLE;
                    again   = 1'b0;
                end else if (i_byte == 8'd0) begin
                    c0_v    = 1'b1;
                    c0.kind = K_UNTERM;
                end else begin
                    if (i_byte == "\n" && r_line != LineMax) n_line = r_line + 1'b1;
                    again = 1'b0;
                end
            end
            default: ;
        endcase

        if (again) begin
            n_mode = M_IDLE;
            if (is_letter(i_byte)) begin
                n_mode   = M_KEY;
                n_begin  = r_pos;
                n_prefix = {40'd0, i_byte};
            end else if (is_dig(i_byte) || i_byte == "-") begin
                n_mode  = M_INT;
                n_begin = r_pos;
            end else begin
                case (i_byte)
                    8'd0: begin
                        id_v    = 1'b1;
                        id.kind = K_END;
                        id.len  = '0;
                    end
                    " ", 8'h0d, 8'h09: ;
                    "\n": if (r_line != LineMax) n_line = r_line + 1'b1;
                    "$":  n_mode = M_COMMENT;
                    "\"": begin
                        n_mode  = M_STRING;
                        n_begin = pos_inc(r_pos);
                    end
                    "#": begin
                        n_mode  = M_HEX;
                        n_begin = pos_inc(r_pos);
                    end
                    "=": begin id_v = 1'b1; id.kind = K_EQUAL;  end
                    "{": begin id_v = 1'b1; id.kind = K_LBRACE; end
                    "(": begin id_v = 1'b1; id.kind = K_LPAREN; end
                    "}": begin id_v = 1'b1; id.kind = K_RBRACE; end
                    ")": begin id_v = 1'b1; id.kind = K_RPAREN; end
                    ";": begin id_v = 1'b1; id.kind = K_SEMI;   end
                    ",": begin id_v = 1'b1; id.kind = K_COMMA;  end
                    default: id_v = 1'b1;
                endcase
            end
        end

        // End of text restarts the position and line counters
        if (i_byte == 8'd0) begin
            n_mode = M_IDLE;
            n_pos  = '0;
            n_line = LineW'(1);
        end else begin
            n_pos  = pos_inc(r_pos);
        end
    end

    // Pack the tokens in order
    always_comb begin
        o_bundle.cnt    = 2'(c0_v) + 2'(c1_v) + 2'(id_v);
        o_bundle.tok[0] = c0_v ? c0 : id;
        o_bundle.tok[1] = c1_v ? c1 : id;
        o_bundle.tok[2] = id;
    end
    assign o_push = w_take && (o_bundle.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_line   <= LineW'(1);
            r_prefix <= '0;
        end else if (w_take) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_line   <= n_line;
            r_prefix <= n_prefix;
        end
    end

endmodule

FILE: hw/rtl/ctt_queue.sv
module ctt_queue
    import ctt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_bundle  i_data,
    input  logic     i_pop,
    output t_bundle  o_data,
    output t_qstat   o_stat
);

    t_bundle            r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr, r_rd;
    logic [QPtrW:0]     r_level;
    logic               w_push, w_pop;

    assign o_stat.level = r_level;
    assign o_stat.full  = (r_level == (QPtrW+1)'(QDepth));
    assign o_stat.empty = (r_level == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rd];

    // Store incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_level <= r_level + (QPtrW+1)'(w_push) - (QPtrW+1)'(w_pop);
        end
    end

endmodule

FILE: hw/rtl/ctt_back.sv
module ctt_back
    import ctt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_head,
    input  t_qstat      i_stat,
    output logic        o_pop,
    ctt_token_if.source o_token
);

    logic [1:0] r_idx;
    logic       w_last, w_fire;
    t_token     w_tok;

    assign w_tok  = i_head.tok[r_idx];
    assign w_last = (r_idx == i_head.cnt - 2'd1);
    assign w_fire = o_token.valid && o_token.ready;
    assign o_pop  = w_fire && w_last;

    assign o_token.valid        = !i_stat.empty;
    assign o_token.token_kind   = w_tok.kind;
    assign o_token.start_offset = OutW'(w_tok.start);
    assign o_token.token_length = OutW'(w_tok.len);
    assign o_token.line_number  = w_tok.line;
    assign o_token.last_of_run  = w_last;

    // Step through the tokens of the head word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_fire) begin
            r_idx <= w_last ? 2'd0 : r_idx + 1'b1;
        end
    end

endmodule

FILE: hw/rtl/config_text_tokenizer.sv
// A token is offered once the queue word that holds it is registered and reaches the queue head.
// Throughput: one byte per cycle while the queue is not full; the output side moves one token
// per cycle while ready is high, so a byte raising two or three tokens holds the output until all are taken.
// A four-word queue between the scanner and the output absorbs those bursts.
// Reset (synchronous, active low): idle scan mode, position 0, line 1, queue empty.
module config_text_tokenizer
    import ctt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctt_byte_if.sink    i_text,
    ctt_token_if.source o_token
);

    logic    w_push, w_pop;
    t_bundle w_in, w_head;
    t_qstat  w_stat;

    ctt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_text.valid),
        .i_byte   (i_text.text_byte),
        .i_q_full (w_stat.full),
        .o_ready  (i_text.ready),
        .o_push   (w_push),
        .o_bundle (w_in)
    );

    ctt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_stat)
    );

    ctt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_token (o_token)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full) else $error("queue overflow");

    // Stored words always carry at least one token
    a_nonempty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_stat.empty |-> (w_head.cnt != 2'd0)) else $error("empty word queued");

    // End token is always last of its run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_token.valid && o_token.token_kind == K_END) |-> o_token.last_of_run)
        else $error("end token not last");

    // Queue level rises by one on a push without a pop
    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_stat.level == $past(w_stat.level) + 1'b1))
        else $error("queue level mismatch");

endmodule
